### rtl/core/usb_audio_out_ring_writer_assert.svh
// Assertion macros for the USB audio OUT ring writer.
// Self-contained; included by modules that carry concurrent checks.
`ifndef USB_AUDIO_OUT_RING_WRITER_ASSERT_SVH
`define USB_AUDIO_OUT_RING_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UAOR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uaor check failed");

// Next-cycle implication, disabled during reset.
`define UAOR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uaor check failed");

`endif

### rtl/core/uaor_pkg.sv
// Shared types and constants for the USB audio OUT ring writer.
// No dependencies; compiled first.
package uaor_pkg;

   localparam int RING_SLOTS = 1024;               // power of two, 64..65536
   localparam int RING_AW    = $clog2(RING_SLOTS);
   localparam int ADDR_W     = 10;                 // write_addr field width
   localparam int DMA_W      = 10;
   localparam int WA_W       = 10;
   localparam int TIME_W     = 16;
   localparam int CSR_W      = 16;                 // widest register
   localparam int CSR_IDX_W  = 2;
   localparam int FB_OUT_W   = 19;
   localparam int FB_W       = 21;                 // signed working width

   localparam logic [FB_W-1:0] FB_MID_RATE = FB_W'((64'd44100 * 64'd65536) / 64'd8000);
   localparam logic [FB_W-1:0] FB_MAX      = FB_W'(6 * 65536);
   localparam logic [FB_W-1:0] FB_MIN      = FB_W'(5 * 65536);

   localparam logic [WA_W-1:0]   WRITE_AHEAD_RESET = WA_W'(512);
   localparam logic [TIME_W-1:0] TIMEOUT_RESET     = TIME_W'(6600);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_WIDTH_24   = 2'd0,
      CSR_STREAM_ENABLED    = 2'd1,
      CSR_WRITE_AHEAD_SLOTS = 2'd2,
      CSR_TIMEOUT_TICKS     = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_DATA = 1'b0,
      MODE_POLL = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 write_valid;
      logic [ADDR_W-1:0]    write_addr;
      logic signed [31:0]   write_data;
      logic                 feedback_valid;
      logic [FB_OUT_W-1:0]  feedback_value;
      logic                 underrun;
      logic                 timed_out;
      logic                 streaming;
      logic                 spk_on;
   } rsp_beat_type;

endpackage

### rtl/core/uaor_if.sv
// Valid/ready channel interfaces for the USB audio OUT ring writer.
// Depends on uaor_pkg for field widths.
interface uaor_req_if;
   import uaor_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [7:0]           data_byte;
   logic [DMA_W-1:0]     dma_offset;
   logic [TIME_W-1:0]    now_time;
   logic                 headphone_in;
   logic                 line_left_in;
   logic                 line_right_in;

   modport source (output valid, mode, data_byte, dma_offset, now_time,
                   headphone_in, line_left_in, line_right_in, input ready);
   modport sink   (input valid, mode, data_byte, dma_offset, now_time,
                   headphone_in, line_left_in, line_right_in, output ready);
endinterface

interface uaor_rsp_if;
   import uaor_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 write_valid;
   logic [ADDR_W-1:0]    write_addr;
   logic signed [31:0]   write_data;
   logic                 feedback_valid;
   logic [FB_OUT_W-1:0]  feedback_value;
   logic                 underrun;
   logic                 timed_out;
   logic                 streaming;
   logic                 spk_on;

   modport source (output valid, write_valid, write_addr, write_data, feedback_valid,
                   feedback_value, underrun, timed_out, streaming, spk_on,
                   input ready);
   modport sink   (input valid, write_valid, write_addr, write_data, feedback_valid,
                   feedback_value, underrun, timed_out, streaming, spk_on,
                   output ready);
endinterface

### rtl/core/usb_audio_out_ring_writer.sv
// USB audio OUT ring writer: byte assembly, ring pointer, timeout and feedback.
// Depends on uaor_pkg, uaor_if.sv and usb_audio_out_ring_writer_assert.svh.
//
// Usage:
//  - req_chan carries one beat per USB audio byte (mode = data) or per
//    service poll (mode = poll), with the DMA slot, timer and jack detects.
//  - rsp_chan returns exactly one beat per request beat: a ring write when a
//    16- or 24-bit sample completes, an unsigned 3.16 feedback value on a poll while
//    streaming, plus underrun/timeout flags, streaming and speaker enable.
//  - csr_we/csr_index/csr_wdata write the four control registers; write only
//    while no request is outstanding.
//  - Response: registered; held in the skid entry while rsp_chan stalls.
//  - Throughput: one beat per cycle when not stalled. All per-beat work
//    (pointer add, lead subtract, divide by 64 and clamp) is one shallow
//    combinational pass between the request handshake and the response register.
//  - Stall: a response register plus one skid entry sit on rsp_chan;
//    req_chan.ready is a flop (skid empty), so one more beat is taken
//    while a response waits, then the input stalls.
//  - Reset: synchronous, active high; registers return to their defaults
//    (16-bit, disabled, write-ahead 512, timeout 6600), state clears, and
//    both response entries empty. No clearing pass.
module usb_audio_out_ring_writer (
   input  logic                          clock,
   input  logic                          reset,
   uaor_req_if.sink                      req_chan,
   uaor_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [uaor_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uaor_pkg::CSR_W-1:0]    csr_wdata
);
   import uaor_pkg::*;

   `include "usb_audio_out_ring_writer_assert.svh"

   // control registers
   logic                sample_width_24_ff;
   logic                stream_enabled_ff;
   logic [WA_W-1:0]     write_ahead_ff;
   logic [TIME_W-1:0]   timeout_ff;

   // stream state
   logic [RING_AW-1:0]  write_pointer_ff, write_pointer_in;
   logic [1:0]          byte_phase_ff, byte_phase_in;
   logic [23:0]         sample_accum_ff, sample_accum_in;
   logic                stream_active_ff, stream_active_in;
   logic [TIME_W-1:0]   last_rx_time_ff, last_rx_time_in;

   // response register and skid entry
   rsp_beat_type        rsp_beat_ff, skid_beat_ff, beat_in;
   logic                rsp_valid_ff, skid_valid_ff;

   logic                accept;
   logic                jack;
   logic [RING_AW-1:0]  dma_ring, wa_ring, lead_now, lead_fb, placed;
   logic [23:0]         accum_or;
   logic [1:0]          phase_next;
   logic                sample_done;
   logic [TIME_W-1:0]   elapsed;
   logic                active_after_to;
   logic                under;
   logic signed [FB_W-1:0] err, quot, fb;
   csr_index_type       csr_sel;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_sel        = csr_index_type'(csr_index);

   // ---- per-beat datapath ----
   always_comb begin
      jack     = req_chan.headphone_in | req_chan.line_left_in | req_chan.line_right_in;
      dma_ring = RING_AW'(req_chan.dma_offset);
      wa_ring  = RING_AW'(write_ahead_ff);
      placed   = dma_ring + wa_ring;
      lead_now = write_pointer_ff - dma_ring;

      write_pointer_in = write_pointer_ff;
      byte_phase_in    = byte_phase_ff;
      sample_accum_in  = sample_accum_ff;
      stream_active_in = stream_active_ff;
      last_rx_time_in  = last_rx_time_ff;

      beat_in          = '0;

      // byte assembly, little-endian
      case (byte_phase_ff)
         2'd0:    accum_or = sample_accum_ff | {16'b0, req_chan.data_byte};
         2'd1:    accum_or = sample_accum_ff | {8'b0, req_chan.data_byte, 8'b0};
         2'd2:    accum_or = sample_accum_ff | {req_chan.data_byte, 16'b0};
         default: accum_or = sample_accum_ff;
      endcase
      phase_next  = byte_phase_ff + 2'd1;
      sample_done = sample_width_24_ff ? (phase_next >= 2'd3) : (phase_next >= 2'd2);

      // timeout check on poll
      elapsed         = req_chan.now_time - last_rx_time_ff;
      active_after_to = stream_active_ff && !(elapsed > timeout_ff);

      // underrun: lead below half the write-ahead (unreduced register)
      under   = (17'(lead_now) < 17'(write_ahead_ff >> 1));
      lead_fb = under ? wa_ring : lead_now;

      // feedback = nominal - (lead - half ring)/64, truncated toward zero
      err  = FB_W'($signed({1'b0, lead_fb})) - FB_W'(RING_SLOTS / 2);
      quot = err[FB_W-1] ? ((err + FB_W'(63)) >>> 6) : (err >>> 6);
      fb   = $signed(FB_MID_RATE) - quot;
      if (fb > $signed(FB_MAX)) begin
         fb = $signed(FB_MAX);
      end
      if (fb < $signed(FB_MIN)) begin
         fb = $signed(FB_MIN);
      end

      if (req_chan.mode == MODE_DATA) begin
         if (stream_enabled_ff) begin
            last_rx_time_in  = req_chan.now_time;
            stream_active_in = 1'b1;
            if (!stream_active_ff) begin
               write_pointer_in = placed;
            end
            if (sample_done) begin
               beat_in.write_valid = 1'b1;
               beat_in.write_addr  = ADDR_W'(write_pointer_in);
               beat_in.write_data  = sample_width_24_ff ? {accum_or, 8'b0}
                                                        : {accum_or[15:0], 16'b0};
               write_pointer_in    = write_pointer_in + RING_AW'(1);
               byte_phase_in       = 2'd0;
               sample_accum_in     = '0;
            end else begin
               byte_phase_in   = phase_next;
               sample_accum_in = accum_or;
            end
         end
      end else begin
         if (stream_active_ff && !active_after_to) begin
            beat_in.timed_out = 1'b1;
         end
         stream_active_in = active_after_to;
         if (stream_enabled_ff) begin
            if (under) begin
               write_pointer_in = placed;
               beat_in.underrun = 1'b1;
            end
            if (active_after_to) begin
               beat_in.feedback_valid = 1'b1;
               beat_in.feedback_value = FB_OUT_W'(fb);
            end
         end
      end

      beat_in.streaming = stream_active_in;
      beat_in.spk_on    = stream_active_in && !jack;
   end

   // ---- state and control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_width_24_ff <= 1'b0;
         stream_enabled_ff  <= 1'b0;
         write_ahead_ff     <= WRITE_AHEAD_RESET;
         timeout_ff         <= TIMEOUT_RESET;
         write_pointer_ff   <= '0;
         byte_phase_ff      <= '0;
         sample_accum_ff    <= '0;
         stream_active_ff   <= 1'b0;
         last_rx_time_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_sel)
            CSR_SAMPLE_WIDTH_24: begin
               sample_width_24_ff <= csr_wdata[0];
               byte_phase_ff      <= '0;
               sample_accum_ff    <= '0;
            end
            CSR_STREAM_ENABLED: begin
               stream_enabled_ff <= csr_wdata[0];
               byte_phase_ff     <= '0;
               sample_accum_ff   <= '0;
               if (!csr_wdata[0]) begin
                  stream_active_ff <= 1'b0;
               end
            end
            CSR_WRITE_AHEAD_SLOTS: write_ahead_ff <= csr_wdata[WA_W-1:0];
            CSR_TIMEOUT_TICKS:     timeout_ff     <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end else if (accept) begin
         write_pointer_ff <= write_pointer_in;
         byte_phase_ff    <= byte_phase_in;
         sample_accum_ff  <= sample_accum_in;
         stream_active_ff <= stream_active_in;
         last_rx_time_ff  <= last_rx_time_in;
      end
   end

   // ---- response register with one skid entry ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || rsp_chan.ready) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            rsp_beat_ff <= skid_beat_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || rsp_chan.ready) begin
            rsp_beat_ff <= beat_in;
         end else begin
            skid_beat_ff <= beat_in;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.write_valid    = rsp_beat_ff.write_valid;
   assign rsp_chan.write_addr     = rsp_beat_ff.write_addr;
   assign rsp_chan.write_data     = rsp_beat_ff.write_data;
   assign rsp_chan.feedback_valid = rsp_beat_ff.feedback_valid;
   assign rsp_chan.feedback_value = rsp_beat_ff.feedback_value;
   assign rsp_chan.underrun       = rsp_beat_ff.underrun;
   assign rsp_chan.timed_out      = rsp_beat_ff.timed_out;
   assign rsp_chan.streaming      = rsp_beat_ff.streaming;
   assign rsp_chan.spk_on         = rsp_beat_ff.spk_on;

   // ---- checks ----
   `UAOR_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `UAOR_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      accept && rsp_valid_ff && !rsp_chan.ready, skid_valid_ff)
   `UAOR_ASSERT_NOW(a_one_kind, clock, reset, rsp_valid_ff,
      !(rsp_beat_ff.write_valid && rsp_beat_ff.feedback_valid))
   `UAOR_ASSERT_NOW(a_fb_in_range, clock, reset,
      rsp_valid_ff && rsp_beat_ff.feedback_valid,
      rsp_beat_ff.streaming && rsp_beat_ff.feedback_value >= FB_OUT_W'(FB_MIN)
      && rsp_beat_ff.feedback_value <= FB_OUT_W'(FB_MAX))

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for usb_audio_out_ring_writer: sample assembly, ring
// placement, underrun resync, stream timeout and rate feedback, with random stalls.
// Depends on uaor_pkg, uaor_if.sv and the ring writer RTL; needs nothing else.
module tb;
   import uaor_pkg::*;

   // Feedback arithmetic in 16.16: nominal rate 44.1 kHz over 8000 microframes/s.
   localparam longint FB_CENTER = (64'd44100 << 16) / 64'd8000;
   localparam longint FB_CEIL   = 64'd6 << 16;
   localparam longint FB_FLOOR  = 64'd5 << 16;

   // One request beat as the testbench sees it; jacks = {headphone, line L, line R}.
   typedef struct packed {
      mode_type         mode;
      logic [7:0]       data_byte;
      logic [DMA_W-1:0] dma_offset;
      logic [TIME_W-1:0] now_time;
      logic [2:0]       jacks;
   } usb_item_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   uaor_req_if req_chan ();
   uaor_rsp_if rsp_chan ();

   usb_audio_out_ring_writer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the control registers and the stream state.
   // ---------------------------------------------------------------------
   logic              reg_width24;
   logic              reg_enabled;
   logic [WA_W-1:0]   reg_ahead;
   logic [TIME_W-1:0] reg_timeout;

   logic [RING_AW-1:0] st_wptr;
   logic [1:0]         st_phase;
   logic [23:0]        st_accum;
   logic               st_active;
   logic [TIME_W-1:0]  st_last_rx;

   rsp_beat_type due_beats[$];   // response beats owed by the DUT, oldest first
   int           fault_count = 0;
   logic [15:0]  tick_now = '0;  // running timer used by the stream traffic
   bit           src_steady = 1'b0;
   bit           sink_steady = 1'b0;

   function automatic void reset_shadow();
      reg_width24 = 1'b0;
      reg_enabled = 1'b0;
      reg_ahead   = WA_W'(512);
      reg_timeout = TIME_W'(6600);
      st_wptr     = '0;
      st_phase    = '0;
      st_accum    = '0;
      st_active   = 1'b0;
      st_last_rx  = '0;
   endfunction

   // Register writes: width and enable both restart sample assembly;
   // disabling also drops the stream.
   function automatic void shadow_reg_write(csr_index_type idx, logic [CSR_W-1:0] val);
      case (idx)
         CSR_SAMPLE_WIDTH_24: begin
            reg_width24 = val[0];
            st_phase    = '0;
            st_accum    = '0;
         end
         CSR_STREAM_ENABLED: begin
            reg_enabled = val[0];
            st_phase    = '0;
            st_accum    = '0;
            if (!val[0]) st_active = 1'b0;
         end
         CSR_WRITE_AHEAD_SLOTS: reg_ahead = val[WA_W-1:0];
         CSR_TIMEOUT_TICKS:     reg_timeout = val[TIME_W-1:0];
         default: ;
      endcase
   endfunction

   // Works out the response beat for one accepted request and advances the shadow.
   function automatic rsp_beat_type predict_ring_beat(usb_item_type it);
      rsp_beat_type       r;
      logic [RING_AW-1:0] lead;
      logic [TIME_W-1:0]  elapsed;
      int                 err;
      longint             fb;
      r = '0;
      if (it.mode == MODE_DATA) begin
         if (reg_enabled) begin
            st_last_rx = it.now_time;
            // first byte after idle: jump write_ahead slots past the DMA slot
            if (!st_active) begin
               st_wptr   = it.dma_offset + reg_ahead;
               st_active = 1'b1;
            end
            st_accum = st_accum | (24'(it.data_byte) << (8 * st_phase));
            st_phase = st_phase + 2'd1;
            if (st_phase >= (reg_width24 ? 2'd3 : 2'd2)) begin
               r.write_valid = 1'b1;
               r.write_addr  = ADDR_W'(st_wptr);
               r.write_data  = reg_width24 ? {st_accum, 8'h00} : {st_accum[15:0], 16'h0000};
               st_wptr  = st_wptr + 1'b1;
               st_phase = '0;
               st_accum = '0;
            end
         end
      end else begin
         if (st_active) begin
            elapsed = it.now_time - st_last_rx;
            if (elapsed > reg_timeout) begin
               st_active   = 1'b0;
               r.timed_out = 1'b1;
            end
         end
         if (reg_enabled) begin
            // underrun check runs whether or not the stream is live
            lead = st_wptr - it.dma_offset;
            if (lead < (reg_ahead >> 1)) begin
               st_wptr    = it.dma_offset + reg_ahead;
               r.underrun = 1'b1;
            end
            if (st_active) begin
               lead = st_wptr - it.dma_offset;
               err  = int'(lead);
               err  = err - RING_SLOTS / 2;
               fb   = FB_CENTER - longint'(err / 64);   // truncates toward zero
               if (fb > FB_CEIL)  fb = FB_CEIL;
               if (fb < FB_FLOOR) fb = FB_FLOOR;
               r.feedback_valid = 1'b1;
               r.feedback_value = FB_OUT_W'(fb);
            end
         end
      end
      r.streaming = st_active;
      r.spk_on    = st_active && (it.jacks == 3'b000);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
   endfunction

   function automatic usb_item_type make_item(mode_type m, logic [7:0] b,
                                              logic [DMA_W-1:0] dma,
                                              logic [TIME_W-1:0] now, logic [2:0] jacks);
      usb_item_type it;
      it.mode       = m;
      it.data_byte  = b;
      it.dma_offset = dma;
      it.now_time   = now;
      it.jacks      = jacks;
      return it;
   endfunction

   function automatic logic [2:0] jack_pick();
      return ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'b000;
   endfunction

   function automatic usb_item_type noise_item();
      return make_item(mode_type'($urandom_range(0, 1)), 8'($urandom), DMA_W'($urandom),
                       TIME_W'($urandom), 3'($urandom));
   endfunction

   // Valid is left high after acceptance so back-to-back beats need no extra NBA.
   task automatic send_beat(usb_item_type it);
      if (!src_steady && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= it.mode;
      req_chan.data_byte     <= it.data_byte;
      req_chan.dma_offset    <= it.dma_offset;
      req_chan.now_time      <= it.now_time;
      req_chan.headphone_in  <= it.jacks[2];
      req_chan.line_left_in  <= it.jacks[1];
      req_chan.line_right_in <= it.jacks[0];
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      due_beats.push_back(predict_ring_beat(it));
   endtask

   // Poll with the DMA slot chosen so the pointer leads it by `lead` slots.
   task automatic poll_at_lead(logic [RING_AW-1:0] lead, logic [TIME_W-1:0] now,
                               logic [2:0] jacks);
      send_beat(make_item(MODE_POLL, 8'($urandom), DMA_W'(st_wptr - lead), now, jacks));
   endtask

   task automatic send_byte(logic [7:0] b, logic [DMA_W-1:0] dma, logic [TIME_W-1:0] now,
                            logic [2:0] jacks);
      send_beat(make_item(MODE_DATA, b, dma, now, jacks));
   endtask

   // Drop valid and wait for every owed beat (bounded; the end check catches leftovers).
   task automatic wait_idle();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (due_beats.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Only called while idle; one cycle of we, then the task waits with we low.
   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_reg_write(idx, val);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random backpressure and the beat-by-beat check.
   // ---------------------------------------------------------------------
   initial begin : rsp_backpressure
      forever begin
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!sink_steady) begin
            rsp_chan.ready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   function automatic void report_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("ERROR @%0t: %s", $time, msg);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
         report_fault($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
   endfunction

   // Sampled at the edge: ready/valid here are the values the DUT saw.
   always @(posedge clock) begin : result_check
      rsp_beat_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (due_beats.size() == 0) begin
            report_fault("response beat with no request outstanding");
         end else begin
            want = due_beats.pop_front();
            check_field("write_valid",    want.write_valid,    rsp_chan.write_valid);
            check_field("write_addr",     want.write_addr,     rsp_chan.write_addr);
            check_field("write_data",     want.write_data,     rsp_chan.write_data);
            check_field("feedback_valid", want.feedback_valid, rsp_chan.feedback_valid);
            check_field("feedback_value", want.feedback_value, rsp_chan.feedback_value);
            check_field("underrun",       want.underrun,       rsp_chan.underrun);
            check_field("timed_out",      want.timed_out,      rsp_chan.timed_out);
            check_field("streaming",      want.streaming,      rsp_chan.streaming);
            check_field("spk_on",         want.spk_on,         rsp_chan.spk_on);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------
   // Out of reset the stream is disabled: bytes are dropped, polls do nothing.
   task automatic test_disabled_traffic();
      send_byte(8'hFF, 10'd1023, 16'hFFFF, 3'b111);
      send_beat(make_item(MODE_POLL, 8'h00, 10'd0, 16'h0000, 3'b000));
   endtask

   // 16-bit extremes; first byte at DMA 1023 makes the placement wrap the ring.
   task automatic test_16bit_samples();
      wait_idle();
      write_reg(CSR_STREAM_ENABLED, CSR_W'(1));
      send_byte(8'h00, 10'd1023, 16'd100, 3'b000);
      send_byte(8'h80, 10'd0,    16'd101, 3'b001);   // most negative
      send_byte(8'hFF, 10'd0,    16'd102, 3'b010);
      send_byte(8'h7F, 10'd0,    16'd103, 3'b100);   // most positive
   endtask

   task automatic test_24bit_samples();
      wait_idle();
      write_reg(CSR_SAMPLE_WIDTH_24, CSR_W'(1));
      send_byte(8'h00, 10'd0, 16'd110, 3'b000);
      send_byte(8'h00, 10'd0, 16'd111, 3'b011);
      send_byte(8'h80, 10'd0, 16'd112, 3'b000);
      send_byte(8'hFF, 10'd0, 16'd113, 3'b110);
      send_byte(8'hFF, 10'd0, 16'd114, 3'b101);
      send_byte(8'h7F, 10'd0, 16'd115, 3'b000);
   endtask

   // Width write mid-sample restarts assembly; disabling drops the stream.
   task automatic test_assembly_restart();
      send_byte(8'hAA, 10'd0, 16'd120, 3'b000);
      wait_idle();
      write_reg(CSR_SAMPLE_WIDTH_24, CSR_W'(0));
      send_byte(8'h34, 10'd0, 16'd121, 3'b000);
      send_byte(8'h12, 10'd0, 16'd122, 3'b000);
      wait_idle();
      write_reg(CSR_STREAM_ENABLED, CSR_W'(0));
      send_byte(8'h55, 10'd0, 16'd123, 3'b000);
      poll_at_lead(10'd0, 16'd124, 3'b000);
      wait_idle();
      write_reg(CSR_STREAM_ENABLED, CSR_W'(1));
   endtask

   // Feedback at lead extremes, underrun thresholds, timeouts incl. timer wrap.
   task automatic test_poll_paths();
      send_byte(8'h01, 10'd0, 16'd1000, 3'b000);
      send_byte(8'h02, 10'd0, 16'd1001, 3'b000);
      poll_at_lead(10'd1023, 16'd1010, 3'b000);   // largest lead
      poll_at_lead(10'd0,    16'd1011, 3'b000);   // underrun, resync
      poll_at_lead(10'd255,  16'd1012, 3'b000);   // one below half write-ahead
      poll_at_lead(10'd256,  16'd1013, 3'b000);   // exactly half: no underrun
      wait_idle();
      write_reg(CSR_TIMEOUT_TICKS, CSR_W'(100));
      send_byte(8'h03, 10'd0, 16'd65500, 3'b000);
      poll_at_lead(10'd300, 16'd64, 3'b000);       // elapsed 100 across wrap: still live
      poll_at_lead(10'd300, 16'd65, 3'b000);       // elapsed 101: timed out
      poll_at_lead(10'd10,  16'd66, 3'b000);       // underrun while not streaming
      send_byte(8'h04, 10'd0, 16'd70, 3'b000);
      wait_idle();
      write_reg(CSR_TIMEOUT_TICKS, CSR_W'(0));
      poll_at_lead(10'd600, 16'd70, 3'b000);
      poll_at_lead(10'd600, 16'd71, 3'b000);
   endtask

   // Write-ahead below 2: half threshold is zero, so never an underrun.
   task automatic test_short_write_ahead();
      wait_idle();
      write_reg(CSR_WRITE_AHEAD_SLOTS, CSR_W'(1));
      write_reg(CSR_TIMEOUT_TICKS, 16'hFFFF);
      send_byte(8'h10, 10'd512, 16'd200, 3'b000);
      poll_at_lead(10'd0, 16'd201, 3'b000);
      wait_idle();
      write_reg(CSR_WRITE_AHEAD_SLOTS, CSR_W'(0));
      poll_at_lead(10'd0, 16'd202, 3'b000);
   endtask

   // ---------------------------------------------------------------------
   // Random stream traffic: mostly bursts of whole samples followed by a poll,
   // with noise beats, ragged bursts, restarts and enable toggles mixed in.
   // ---------------------------------------------------------------------
   task automatic run_stream_phase(int n_items, bit width24, logic [CSR_W-1:0] ahead_val,
                                   logic [CSR_W-1:0] tmo_val);
      int                 sent;
      int                 n_bytes;
      int                 pick;
      logic [RING_AW-1:0] lead;
      logic [TIME_W-1:0]  poll_now;
      sent = 0;
      wait_idle();
      write_reg(CSR_SAMPLE_WIDTH_24, CSR_W'(width24));
      write_reg(CSR_WRITE_AHEAD_SLOTS, ahead_val);
      write_reg(CSR_TIMEOUT_TICKS, tmo_val);
      write_reg(CSR_STREAM_ENABLED, CSR_W'(1));
      while (sent < n_items) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_beat(noise_item());
            sent++;
         end else if (pick == 1) begin
            // short disabled stretch; those beats are ignored and not counted
            wait_idle();
            write_reg(CSR_STREAM_ENABLED, CSR_W'(0));
            repeat ($urandom_range(1, 3)) send_beat(noise_item());
            wait_idle();
            write_reg(CSR_STREAM_ENABLED, CSR_W'(1));
         end else if (pick == 2) begin
            // stray byte then a width rewrite: partial sample is discarded
            send_byte(8'($urandom), DMA_W'($urandom), tick_now, jack_pick());
            sent++;
            wait_idle();
            write_reg(CSR_SAMPLE_WIDTH_24, CSR_W'(width24));
         end else begin
            n_bytes = $urandom_range(1, 6) * (width24 ? 3 : 2);
            if ($urandom_range(0, 9) == 0) n_bytes += $urandom_range(1, 2);
            repeat (n_bytes) begin
               tick_now += 16'($urandom_range(0, 2));
               send_byte(8'($urandom), DMA_W'($urandom), tick_now, jack_pick());
            end
            sent += n_bytes;
            case ($urandom_range(0, 4))
               0:       lead = RING_AW'($urandom);
               1:       lead = RING_AW'(reg_ahead >> 1) - RING_AW'($urandom_range(0, 1));
               default: lead = RING_AW'(reg_ahead) + RING_AW'($urandom_range(0, 16)) - 10'd8;
            endcase
            case ($urandom_range(0, 7))
               0:       poll_now = st_last_rx + reg_timeout;           // at the limit
               1:       poll_now = st_last_rx + reg_timeout + 16'd1;   // one past
               2:       poll_now = TIME_W'($urandom);
               default: poll_now = tick_now + TIME_W'($urandom_range(0, 40));
            endcase
            tick_now = poll_now;
            poll_at_lead(lead, poll_now, jack_pick());
            sent++;
         end
         if ($urandom_range(0, 24) == 0) src_steady = !src_steady;
         if ($urandom_range(0, 24) == 0) sink_steady = !sink_steady;
      end
   endtask

   task automatic test_random_traffic();
      src_steady  = 1'b0;
      sink_steady = 1'b0;
      run_stream_phase(200, 1'b0, CSR_W'(512), CSR_W'(6600));
      src_steady = 1'b1;
      run_stream_phase(200, 1'b1, CSR_W'(2), CSR_W'(0));
      src_steady  = 1'b0;
      sink_steady = 1'b1;
      run_stream_phase(200, 1'b0, CSR_W'(1023), 16'hFFFF);
      sink_steady = 1'b0;
      run_stream_phase(200, 1'b1, CSR_W'(0), CSR_W'(1));
      run_stream_phase(200, 1'b0, CSR_W'(1), CSR_W'(40));
      run_stream_phase(200, 1'b1, CSR_W'($urandom_range(2, 1023)), CSR_W'($urandom));
      run_stream_phase(200, 1'b0, CSR_W'($urandom), CSR_W'($urandom_range(0, 2000)));
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : test_sequence
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_SAMPLE_WIDTH_24;
      csr_wdata              <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.mode          <= MODE_DATA;
      req_chan.data_byte     <= '0;
      req_chan.dma_offset    <= '0;
      req_chan.now_time      <= '0;
      req_chan.headphone_in  <= 1'b0;
      req_chan.line_left_in  <= 1'b0;
      req_chan.line_right_in <= 1'b0;
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_traffic();
      test_16bit_samples();
      test_24bit_samples();
      test_assembly_restart();
      test_poll_paths();
      test_short_write_ahead();
      test_random_traffic();

      // drain, then wait so that any stray beat can show up
      wait_idle();
      repeat (10) @(posedge clock);
      if (due_beats.size() != 0)
         report_fault($sformatf("%0d response beats never arrived", due_beats.size()));
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Hang guard: well beyond the slowest legal run (~2 ms of traffic).
   initial begin : run_limit
      #(20_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### usb_audio_out_ring_writer.f
+incdir+rtl/core
rtl/core/uaor_pkg.sv
rtl/core/uaor_if.sv
rtl/core/usb_audio_out_ring_writer.sv
tb/tb.sv
